>>> hdl/lru_key_value_cache_core_defines.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
// concurrent assertion clocked on clk, disabled in reset
`define LKV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// assertion that also runs during reset
`define LKV_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> hdl/lkv_pkg.sv
// Package for the LRU key-value cache: sizes, opcodes, queue word type.
// No dependencies.
package lkv_pkg;
	localparam int TableDepth = 16;
	localparam int KeyBits = 32;
	localparam int ValueBits = 32;
	localparam int IdxBits = $clog2(TableDepth);
	localparam int CntBits = $clog2(TableDepth + 1);
	localparam int CapBits = 5;
	localparam logic [CapBits-1:0] CapReset = CapBits'(TableDepth);

	typedef enum logic [1:0] {
		OP_GET = 2'd0,
		OP_PUT = 2'd1,
		OP_ERASE = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [KeyBits-1:0] key;
		logic [ValueBits-1:0] value;
	} cmd_t;
endpackage

>>> hdl/lkv_front.sv
// Front end: accepts input words into a two-entry command queue.
// Depends on lkv_pkg.
module lkv_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lkv_pkg::cmd_t in_cmd,
	output logic q_valid,
	input logic q_ready,
	output lkv_pkg::cmd_t q_cmd
);
	lkv_pkg::cmd_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_cmd = mem_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

>>> hdl/lkv_back.sv
// Back end: parallel key match, rank update, insert/evict, result register.
// Depends on lkv_pkg.
module lkv_back (
	input logic clk,
	input logic arst_n,
	input logic [lkv_pkg::CapBits-1:0] capacity,
	input logic q_valid,
	output logic q_ready,
	input lkv_pkg::cmd_t q_cmd,
	output logic out_valid,
	input logic out_ready,
	output logic out_hit,
	output logic [lkv_pkg::ValueBits-1:0] out_value,
	output logic [lkv_pkg::CntBits-1:0] out_occ
);
	localparam int N = lkv_pkg::TableDepth;
	localparam int IB = lkv_pkg::IdxBits;
	localparam int CB = lkv_pkg::CntBits;

	logic [N-1:0] valid_q;
	logic [lkv_pkg::KeyBits-1:0] key_q [N];
	logic [lkv_pkg::ValueBits-1:0] val_q [N];
	logic [IB-1:0] rank_q [N];
	logic [CB-1:0] count_q;

	logic [N-1:0] match, evict_sel;
	logic hit, go;
	logic [IB-1:0] hidx, free_idx;
	logic [IB-1:0] hrank;
	logic [lkv_pkg::ValueBits-1:0] hval;
	logic [CB-1:0] cap_eff;
	logic do_touch, do_erase, do_insert, do_evict;
	logic [N-1:0] valid_n;
	logic [IB-1:0] rank_n [N];
	logic [CB-1:0] count_n;
	logic [N-1:0] valid_after_evict;
	lkv_pkg::op_t op;

	assign op = lkv_pkg::op_t'(q_cmd.opcode);
	assign q_ready = !out_valid || out_ready;
	assign go = q_valid && q_ready;

	always_comb begin
		hidx = '0;
		hrank = '0;
		hval = '0;
		for (int i = 0; i < N; i++) begin
			match[i] = valid_q[i] && key_q[i] == q_cmd.key;
			evict_sel[i] = valid_q[i] && CB'(rank_q[i]) == count_q - CB'(1);
		end
		for (int i = 0; i < N; i++) begin
			if (match[i]) begin
				hidx = IB'(i);
				hrank = rank_q[i];
				hval = val_q[i];
			end
		end
		hit = |match;
		cap_eff = (CB'(capacity) > CB'(N)) ? CB'(N) : CB'(capacity);
		do_touch = hit && (op == lkv_pkg::OP_GET ||
			(op == lkv_pkg::OP_PUT && capacity != '0));
		do_erase = hit && op == lkv_pkg::OP_ERASE;
		do_insert = !hit && op == lkv_pkg::OP_PUT && capacity != '0;
		do_evict = do_insert && count_q >= cap_eff && count_q != '0;
		valid_after_evict = do_evict ? (valid_q & ~evict_sel) : valid_q;
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!valid_after_evict[i]) free_idx = IB'(i);
		end
		valid_n = valid_q;
		count_n = count_q;
		for (int i = 0; i < N; i++) rank_n[i] = rank_q[i];
		if (do_touch) begin
			for (int i = 0; i < N; i++) begin
				if (valid_q[i] && rank_q[i] < hrank) rank_n[i] = rank_q[i] + IB'(1);
			end
			rank_n[hidx] = '0;
		end else if (do_erase) begin
			valid_n[hidx] = 1'b0;
			for (int i = 0; i < N; i++) begin
				if (valid_q[i] && rank_q[i] > hrank) rank_n[i] = rank_q[i] - IB'(1);
			end
			count_n = count_q - CB'(1);
		end else if (do_insert) begin
			// evicted entry holds the oldest rank, so survivors just age by one
			for (int i = 0; i < N; i++) begin
				if (valid_after_evict[i]) rank_n[i] = rank_q[i] + IB'(1);
			end
			valid_n = valid_after_evict;
			valid_n[free_idx] = 1'b1;
			rank_n[free_idx] = '0;
			if (!do_evict) count_n = count_q + CB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			for (int i = 0; i < N; i++) rank_q[i] <= rank_n[i];
			if (do_touch && op == lkv_pkg::OP_PUT) val_q[hidx] <= q_cmd.value;
			if (do_insert) begin
				key_q[free_idx] <= q_cmd.key;
				val_q[free_idx] <= q_cmd.value;
			end
			out_hit <= hit;
			out_value <= (hit && op == lkv_pkg::OP_GET) ? hval : '0;
			out_occ <= count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (go) begin
				valid_q <= valid_n;
				count_q <= count_n;
			end
			if (go) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end
endmodule

>>> hdl/lru_key_value_cache_core.sv
// Top level of the LRU key-value cache: config register, front queue, back end.
// Depends on lkv_pkg, lkv_front, lkv_back.
// Sixteen-entry fully associative key-value cache with LRU replacement. One
// operation per cycle while the output is not stalled: the back end compares
// all keys and updates all recency ranks combinationally over a flip-flop
// table, and registers the result word as the operation leaves the two-word
// input queue. Write capacity only while idle.
module lru_key_value_cache_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [4:0] cfg_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [63:0] s_axis_tdata, // lookup_key[31:0], write_value[63:32]
	input logic [1:0] s_axis_tuser, // opcode
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [39:0] m_axis_tdata, // read_value[31:0], occupancy[36:32], zero
	output logic m_axis_tuser // hit
);
	logic [lkv_pkg::CapBits-1:0] capacity_q;
	lkv_pkg::cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;
	logic [lkv_pkg::ValueBits-1:0] rd_value;
	logic [lkv_pkg::CntBits-1:0] occ;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkv_pkg::CapReset;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	assign in_cmd.opcode = s_axis_tuser;
	assign in_cmd.key = s_axis_tdata[31:0];
	assign in_cmd.value = s_axis_tdata[63:32];

	lkv_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	lkv_back u_back (
		.clk, .arst_n,
		.capacity(capacity_q),
		.q_valid, .q_ready, .q_cmd,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_hit(m_axis_tuser), .out_value(rd_value), .out_occ(occ)
	);

	assign m_axis_tdata = {3'b000, occ, rd_value};
endmodule

>>> hdl/lkv_checker.sv
// Port-level checker for the LRU cache, bound to the top level.
// Depends on lru_key_value_cache_core_defines.svh.
`include "lru_key_value_cache_core_defines.svh"
module lkv_checker (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic m_axis_tuser
);
	`LKV_ASSERT(a_occ_range, m_axis_tvalid |-> m_axis_tdata[36:32] <= 5'd16, "occupancy over depth")
	`LKV_ASSERT(a_miss_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0, "miss data")
	`LKV_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[39:37] == 3'd0, "pad bits")
	`LKV_ASSERT_ALWAYS(a_rst_idle, !arst_n |=> !m_axis_tvalid || arst_n, "valid in reset")
endmodule

bind lru_key_value_cache_core lkv_checker u_lkv_checker (.*);
